/* hdl/llfr_pkg.sv */
// ----------------------------------------------------------------------------
// llfr_pkg
// Shared widths, register indexes, reset values and the request/response
// structs between the ramp controller and its serial multiply/divide unit.
// ----------------------------------------------------------------------------
package llfr_pkg;

    localparam int LEVEL_BITS    = 8;
    localparam int PERIOD_BITS   = 16;
    localparam int POS_BITS      = PERIOD_BITS + 1;
    localparam int PROD_BITS     = LEVEL_BITS + PERIOD_BITS;
    localparam int SUM_BITS      = PROD_BITS + 2;
    localparam int MD_CNT_BITS   = $clog2(PROD_BITS);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = (PERIOD_BITS > LEVEL_BITS) ? PERIOD_BITS : LEVEL_BITS;

    localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX       = '1;
    localparam logic [LEVEL_BITS-1:0]  RST_START_LEVEL = '0;
    localparam logic [LEVEL_BITS-1:0]  RST_END_LEVEL   = LEVEL_BITS'(255);
    localparam logic [PERIOD_BITS-1:0] RST_PERIOD      = PERIOD_BITS'(35);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_LEVEL  = CFG_IDX_BITS'(0),
        REG_END_LEVEL    = CFG_IDX_BITS'(1),
        REG_PERIOD_TICKS = CFG_IDX_BITS'(2),
        REG_ONE_SHOT     = CFG_IDX_BITS'(3)
    } t_cfg_reg;

    typedef struct packed {
        logic                   start;
        logic [LEVEL_BITS-1:0]  mult;
        logic [PERIOD_BITS-1:0] mcand;
        logic [PERIOD_BITS-1:0] divisor;
    } t_md_req;

    typedef struct packed {
        logic                 done;
        logic [PROD_BITS-1:0] quot;
    } t_md_rsp;

endpackage

/* hdl/llfr_mul_div.sv */
// ----------------------------------------------------------------------------
// llfr_mul_div
// Bit-serial unsigned multiply (shift-add, LSB first) followed by a
// restoring divide, one quotient bit per cycle, in one shared register.
// ----------------------------------------------------------------------------
module llfr_mul_div
    import llfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } t_md_state;

    t_md_state              r_state, n_state;
    logic [MD_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [PROD_BITS-1:0]   r_acc, n_acc;
    logic [PERIOD_BITS-1:0] r_rem, n_rem;
    logic [PERIOD_BITS-1:0] r_mcand, n_mcand;
    logic [PERIOD_BITS-1:0] r_div, n_div;
    logic                   r_done, n_done;

    always_comb begin
        logic [PERIOD_BITS:0] t_sum;
        logic [PERIOD_BITS:0] t_trial;
        logic                 t_ge;
        logic [PERIOD_BITS:0] t_rem;

        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_mcand = r_mcand;
        n_div   = r_div;
        n_done  = 1'b0;

        t_sum   = {1'b0, r_acc[PROD_BITS-1:LEVEL_BITS]}
                + (r_acc[0] ? {1'b0, r_mcand} : '0);
        t_trial = {r_rem, r_acc[PROD_BITS-1]};
        t_ge    = (t_trial >= {1'b0, r_div});
        t_rem   = t_ge ? (t_trial - {1'b0, r_div}) : t_trial;

        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_acc   = {{PERIOD_BITS{1'b0}}, i_req.mult};
                    n_mcand = i_req.mcand;
                    n_div   = i_req.divisor;
                    n_cnt   = MD_CNT_BITS'(LEVEL_BITS - 1);
                    n_state = U_MUL;
                end
            end
            U_MUL: begin
                // add the multiplicand into the upper PERIOD_BITS bits when bit 0 is set, shift right
                n_acc = {t_sum, r_acc[LEVEL_BITS-1:1]};
                if (r_cnt == '0) begin
                    n_cnt   = MD_CNT_BITS'(PROD_BITS - 1);
                    n_rem   = '0;
                    n_state = U_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            U_DIV: begin
                // shift one dividend bit into the remainder, shift quotient bit in
                n_rem = t_rem[PERIOD_BITS-1:0];
                n_acc = {r_acc[PROD_BITS-2:0], t_ge};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_mcand <= n_mcand;
        r_div   <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc;

endmodule

/* hdl/linear_light_fade_ramp_unit.sv */
// ----------------------------------------------------------------------------
// linear_light_fade_ramp_unit
// Light level ramp between two levels over a programmable number of ticks,
// in one-shot or back-and-forth glow mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / i_restart / o_stall): each item is one tick
//   (i_restart = 0) or a restart that reloads the ramp from the start/end
//   level registers (i_restart = 1). Every item gives exactly one result
//   item on the output channel (o_valid / o_light_level / o_finished),
//   which the receiver holds off with i_stall.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) is always ready; write it only while the block is idle.
//   Flow: one item at a time; o_stall is high from acceptance until the
//   result moves into the output register. A tick that moves along the
//   ramp runs the serial multiply/divide unit, a multiply and then a
//   restoring divide, before its result is queued for the output register.
//   A restart, a tick after a finished fade or the final tick of a one-shot
//   fade skips the unit and goes straight to the output stage.
//   Reset: registers return to start 0, end 255, period 35, glow mode;
//   the ramp sits at position -1, not finished. When the receiver stalls,
//   the result holds in the output register and the next item may be
//   accepted and computed meanwhile; its result waits until the output
//   register frees up.
// ----------------------------------------------------------------------------
module linear_light_fade_ramp_unit
    import llfr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_restart,
    output logic                     o_stall,
    output logic                     o_valid,
    output logic [LEVEL_BITS-1:0]    o_light_level,
    output logic                     o_finished,
    input  logic                     i_stall,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    // configuration registers
    logic [LEVEL_BITS-1:0]  r_cfg_start;
    logic [LEVEL_BITS-1:0]  r_cfg_end;
    logic [PERIOD_BITS-1:0] r_cfg_period;
    logic                   r_cfg_one_shot;

    // ramp state
    t_state                     r_state, n_state;
    logic [LEVEL_BITS-1:0]      r_from, n_from;
    logic [LEVEL_BITS-1:0]      r_to, n_to;
    logic signed [POS_BITS-1:0] r_pos, n_pos;
    logic                       r_done, n_done;
    logic                       r_neg, n_neg;

    // result waiting for the output register, and the output register
    logic [LEVEL_BITS-1:0] r_res_level, n_res_level;
    logic                  r_res_fin, n_res_fin;
    logic                  r_out_valid, n_out_valid;
    logic [LEVEL_BITS-1:0] r_out_level, n_out_level;
    logic                  r_out_fin, n_out_fin;

    logic                   w_accept;
    logic [PERIOD_BITS-1:0] w_period;
    t_md_req                w_md_req;
    t_md_rsp                w_md_rsp;

    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // a period of zero runs as a period of one
    assign w_period = (r_cfg_period == '0) ? PERIOD_BITS'(1) : r_cfg_period;

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start    <= RST_START_LEVEL;
            r_cfg_end      <= RST_END_LEVEL;
            r_cfg_period   <= RST_PERIOD;
            r_cfg_one_shot <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_START_LEVEL:  r_cfg_start    <= i_cfg_data[LEVEL_BITS-1:0];
                REG_END_LEVEL:    r_cfg_end      <= i_cfg_data[LEVEL_BITS-1:0];
                REG_PERIOD_TICKS: r_cfg_period   <= i_cfg_data[PERIOD_BITS-1:0];
                REG_ONE_SHOT:     r_cfg_one_shot <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Item handling: step the ramp on acceptance, then either hand the
    // level formula to the serial unit or queue the result directly.
    // ------------------------------------------------------------------------
    always_comb begin
        logic signed [POS_BITS-1:0] t_pos_inc;
        logic signed [POS_BITS-1:0] t_pos_sub;
        logic                       t_wrap;
        logic [LEVEL_BITS:0]        t_diff;
        logic [LEVEL_BITS:0]        t_mag;
        logic signed [SUM_BITS-1:0] t_from_ext;
        logic signed [SUM_BITS-1:0] t_q_ext;
        logic signed [SUM_BITS-1:0] t_sum;

        n_state     = r_state;
        n_from      = r_from;
        n_to        = r_to;
        n_pos       = r_pos;
        n_done      = r_done;
        n_neg       = r_neg;
        n_res_level = r_res_level;
        n_res_fin   = r_res_fin;
        n_out_valid = r_out_valid;
        n_out_level = r_out_level;
        n_out_fin   = r_out_fin;

        t_pos_inc = r_pos + POS_BITS'(1);
        t_pos_sub = t_pos_inc - $signed({1'b0, w_period});
        t_wrap    = (r_pos >= $signed({1'b0, w_period}));

        // level = from +/- |to - from| * pos / period, before the clamp
        t_from_ext = $signed({{(SUM_BITS-LEVEL_BITS){1'b0}}, r_from});
        t_q_ext    = $signed({2'b00, w_md_rsp.quot});
        t_sum      = r_neg ? (t_from_ext - t_q_ext) : (t_from_ext + t_q_ext);

        w_md_req       = '0;
        w_md_req.start = 1'b0;

        // drop the output item once the receiver takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOAD;
                    if (i_restart) begin
                        n_from      = r_cfg_start;
                        n_to        = r_cfg_end;
                        n_pos       = '1;
                        n_done      = 1'b0;
                        n_res_level = r_cfg_start;
                        n_res_fin   = 1'b0;
                    end else if (r_done) begin
                        // finished fade: hold at the end level
                        n_res_level = r_to;
                        n_res_fin   = 1'b1;
                    end else if (t_wrap && r_cfg_one_shot) begin
                        n_pos       = t_pos_inc;
                        n_done      = 1'b1;
                        n_res_level = r_to;
                        n_res_fin   = 1'b1;
                    end else begin
                        if (t_wrap) begin
                            // end of a glow leg: reverse direction
                            n_from = r_to;
                            n_to   = r_from;
                            n_pos  = t_pos_sub;
                        end else begin
                            n_pos = t_pos_inc;
                        end
                        n_res_fin = 1'b0;
                        n_state   = S_CALC;
                    end
                end
            end
            S_CALC: begin
                if (w_md_rsp.done) begin
                    // clamp the level to range
                    if (t_sum[SUM_BITS-1]) begin
                        n_res_level = '0;
                    end else if (t_sum > $signed({{(SUM_BITS-LEVEL_BITS){1'b0}}, LEVEL_MAX}))
                    begin
                        n_res_level = LEVEL_MAX;
                    end else begin
                        n_res_level = t_sum[LEVEL_BITS-1:0];
                    end
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // advance into the output register once it is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_res_level;
                    n_out_fin   = r_res_fin;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // operands for the serial unit come from the stepped ramp state
        t_diff = {1'b0, n_to} - {1'b0, n_from};
        t_mag  = t_diff[LEVEL_BITS] ? ((LEVEL_BITS+1)'(0) - t_diff) : t_diff;
        if ((r_state == S_IDLE) && (n_state == S_CALC)) begin
            n_neg = t_diff[LEVEL_BITS];
        end
        w_md_req.start   = (r_state == S_IDLE) && (n_state == S_CALC);
        w_md_req.mult    = t_mag[LEVEL_BITS-1:0];
        w_md_req.mcand   = n_pos[PERIOD_BITS-1:0];
        w_md_req.divisor = w_period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_from      <= RST_START_LEVEL;
            r_to        <= RST_END_LEVEL;
            r_pos       <= '1;
            r_done      <= 1'b0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_from      <= n_from;
            r_to        <= n_to;
            r_pos       <= n_pos;
            r_done      <= n_done;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_level <= n_res_level;
        r_res_fin   <= n_res_fin;
        r_out_level <= n_out_level;
        r_out_fin   <= n_out_fin;
    end

    llfr_mul_div u_mul_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    assign o_valid       = r_out_valid;
    assign o_light_level = r_out_level;
    assign o_finished    = r_out_fin;

endmodule
